// ===== hw/rtl/lfpa_pkg.sv =====
package lfpa_pkg;

	localparam int PAGES    = 4096;
	localparam int PAGE_W   = 12;
	localparam int CNT_W    = 13;
	localparam int BIT_W    = 6;
	localparam int ROW_W    = PAGE_W - BIT_W;
	localparam int WORD_W   = 1 << BIT_W;
	localparam int ROWS     = 1 << ROW_W;

	localparam logic REQ_ALLOC   = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_CALC,
		ST_DONE
	} st_t;

	typedef struct packed {
		logic               en;
		logic [ROW_W-1:0]   addr;
		logic [WORD_W-1:0]  data;
	} ram_wr_t;

	// result of a lowest-set-bit search over one 64-bit word
	typedef struct packed {
		logic               found;
		logic [BIT_W-1:0]   idx;
	} lsb_t;

endpackage

// ===== hw/rtl/lfpa_ram.sv =====
module lfpa_ram (
	input  logic                          clk,
	input  lfpa_pkg::ram_wr_t             wr,
	input  logic                          rd_en,
	input  logic [lfpa_pkg::ROW_W-1:0]    rd_addr,
	output logic [lfpa_pkg::WORD_W-1:0]   rd_data
);

	logic [lfpa_pkg::WORD_W-1:0] mem [lfpa_pkg::ROWS];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/lfpa_lsb.sv =====
module lfpa_lsb (
	input  logic [lfpa_pkg::WORD_W-1:0] vec,
	output lfpa_pkg::lsb_t              res
);

	always_comb begin
		res.found = |vec;
		res.idx   = '0;
		// scan from the top so the lowest set bit wins
		for (int i = lfpa_pkg::WORD_W - 1; i >= 0; i--) begin
			if (vec[i]) begin
				res.idx = lfpa_pkg::BIT_W'(i);
			end
		end
	end

endmodule

// ===== hw/rtl/lowest_free_page_allocator.sv =====
// Lowest-first page allocator: 64 summary flags in flops over 64 RAM words of 64 page bits.
// Each input word passes through accept, summary search and RAM read, leaf search and
// write-back, then result load; a failed allocate or invalid release skips the write-back.
// A new word is accepted only after the last result is loaded, which waits on out_ready.
// Reset and pool-size writes leave the RAM as it is: unwritten rows read as the fill pattern.
module lowest_free_page_allocator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lfpa_pkg::CNT_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          req_type,
	input  logic [lfpa_pkg::PAGE_W-1:0]   page_number,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lfpa_pkg::PAGE_W-1:0]   granted_page,
	output logic                          alloc_failed,
	output logic                          release_invalid,
	output logic [lfpa_pkg::CNT_W-1:0]    free_count
);

	localparam int ROW_W  = lfpa_pkg::ROW_W;
	localparam int BIT_W  = lfpa_pkg::BIT_W;
	localparam int WORD_W = lfpa_pkg::WORD_W;
	localparam int CNT_W  = lfpa_pkg::CNT_W;
	localparam int PAGE_W = lfpa_pkg::PAGE_W;
	localparam int ROWS   = lfpa_pkg::ROWS;

	lfpa_pkg::st_t st_q, st_nxt;

	logic [CNT_W-1:0]  total_q;
	logic [CNT_W-1:0]  free_q;
	logic [ROWS-1:0]   row_vld_q;
	logic [ROWS-1:0]   nz_q;
	logic [ROWS-1:0]   summ;

	logic              req_s1;
	logic [PAGE_W-1:0] page_s1;
	logic [ROW_W-1:0]  row_s1;

	logic [PAGE_W-1:0] res_page_q;
	logic              res_fail_q;
	logic              res_inv_q;
	logic [CNT_W-1:0]  res_cnt_q;
	logic              out_valid_q;

	logic              in_acc, cfg_acc, out_acc;
	logic              look_direct;
	logic              rd_en;
	logic [ROW_W-1:0]  rd_addr;
	logic [WORD_W-1:0] rd_data;
	logic [WORD_W-1:0] cur_word;
	logic [WORD_W-1:0] new_word;
	logic [BIT_W-1:0]  sel_bit;
	logic              rel_set;
	logic              ld_out;
	logic [CNT_W-1:0]  cfg_sat;
	logic              page_bad;

	lfpa_pkg::ram_wr_t wr;
	lfpa_pkg::lsb_t    summ_lsb, leaf_lsb;

	// fill pattern of a row never written since the last pool-size write
	function automatic logic [WORD_W-1:0] row_fill(logic [ROW_W-1:0] row,
			logic [CNT_W-1:0] tot);
		logic [CNT_W-BIT_W-1:0] hi;
		logic [BIT_W-1:0]       lo;
		logic [WORD_W-1:0]      w;
		hi = tot[CNT_W-1:BIT_W];
		lo = tot[BIT_W-1:0];
		if ({1'b0, row} < hi) begin
			w = '1;
		end else if ({1'b0, row} == hi) begin
			w = (WORD_W'(1) << lo) - WORD_W'(1);
		end else begin
			w = '0;
		end
		return w;
	endfunction

	assign in_acc  = in_valid && in_ready;
	assign cfg_acc = cfg_valid && cfg_ready;
	assign out_acc = out_valid_q && out_ready;

	assign cfg_sat  = (cfg_data > CNT_W'(lfpa_pkg::PAGES)) ? CNT_W'(lfpa_pkg::PAGES) : cfg_data;
	assign page_bad = {1'b0, page_s1} >= total_q;

	always_comb begin
		for (int w = 0; w < ROWS; w++) begin
			summ[w] = row_vld_q[w] ? nz_q[w] : (|row_fill(ROW_W'(w), total_q));
		end
	end

	lfpa_lsb u_summ_lsb (
		.vec (summ),
		.res (summ_lsb)
	);

	assign cur_word = row_vld_q[row_s1] ? rd_data : row_fill(row_s1, total_q);

	lfpa_lsb u_leaf_lsb (
		.vec (cur_word),
		.res (leaf_lsb)
	);

	always_comb begin
		if (req_s1 == lfpa_pkg::REQ_ALLOC) begin
			sel_bit  = leaf_lsb.idx;
			new_word = cur_word & ~(WORD_W'(1) << sel_bit);
			rel_set  = 1'b0;
		end else begin
			sel_bit  = page_s1[BIT_W-1:0];
			new_word = cur_word | (WORD_W'(1) << sel_bit);
			rel_set  = !cur_word[sel_bit];
		end
	end

	// a look step with no row to touch: empty map or out-of-pool release
	assign look_direct = (req_s1 == lfpa_pkg::REQ_ALLOC) ? !summ_lsb.found : page_bad;

	// next state
	always_comb begin
		st_nxt = st_q;
		case (st_q)
			lfpa_pkg::ST_IDLE: begin
				if (in_acc) st_nxt = lfpa_pkg::ST_LOOK;
			end
			lfpa_pkg::ST_LOOK: begin
				st_nxt = look_direct ? lfpa_pkg::ST_DONE : lfpa_pkg::ST_CALC;
			end
			lfpa_pkg::ST_CALC: begin
				st_nxt = lfpa_pkg::ST_DONE;
			end
			lfpa_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) st_nxt = lfpa_pkg::ST_IDLE;
			end
			default: st_nxt = lfpa_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready  = 1'b0;
		cfg_ready = 1'b0;
		rd_en     = 1'b0;
		ld_out    = 1'b0;
		wr.en     = 1'b0;
		case (st_q)
			lfpa_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				cfg_ready = !out_valid_q;
			end
			lfpa_pkg::ST_LOOK: rd_en = !look_direct;
			lfpa_pkg::ST_CALC: wr.en = 1'b1;
			lfpa_pkg::ST_DONE: ld_out = !out_valid_q || out_ready;
			default: ;
		endcase
		wr.addr = row_s1;
		wr.data = new_word;
	end

	assign rd_addr = (req_s1 == lfpa_pkg::REQ_ALLOC) ? summ_lsb.idx : page_s1[PAGE_W-1:BIT_W];

	lfpa_ram u_ram (
		.clk     (clk),
		.wr      (wr),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= lfpa_pkg::ST_IDLE;
			total_q     <= CNT_W'(lfpa_pkg::PAGES);
			free_q      <= CNT_W'(lfpa_pkg::PAGES);
			row_vld_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_nxt;
			if (cfg_acc) begin
				total_q   <= cfg_sat;
				free_q    <= cfg_sat;
				row_vld_q <= '0;
			end
			if (wr.en) begin
				row_vld_q[row_s1] <= 1'b1;
				if (req_s1 == lfpa_pkg::REQ_ALLOC) begin
					if (free_q != '0) free_q <= free_q - CNT_W'(1);
				end else if (rel_set) begin
					free_q <= free_q + CNT_W'(1);
				end
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_s1  <= req_type;
			page_s1 <= page_number;
		end
		if (st_q == lfpa_pkg::ST_LOOK) begin
			row_s1     <= rd_addr;
			res_page_q <= '0;
			res_fail_q <= (req_s1 == lfpa_pkg::REQ_ALLOC) && !summ_lsb.found;
			res_inv_q  <= (req_s1 == lfpa_pkg::REQ_RELEASE) && page_bad;
			res_cnt_q  <= free_q;
		end
		if (wr.en) begin
			nz_q[row_s1] <= |new_word;
			if (req_s1 == lfpa_pkg::REQ_ALLOC) begin
				res_page_q <= {row_s1, sel_bit};
				res_cnt_q  <= (free_q != '0) ? free_q - CNT_W'(1) : free_q;
			end else begin
				res_cnt_q <= rel_set ? free_q + CNT_W'(1) : free_q;
			end
		end
		if (ld_out) begin
			granted_page    <= res_page_q;
			alloc_failed    <= res_fail_q;
			release_invalid <= res_inv_q;
			free_count      <= res_cnt_q;
		end
	end

	assign out_valid = out_valid_q;

	a_free_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= total_q)
		else $error("free count above pool size");

	a_cfg_fill: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_acc |=> (free_q == total_q) && (row_vld_q == '0))
		else $error("pool write did not rebuild map");

	a_fail_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && alloc_failed |-> (granted_page == '0) && !release_invalid)
		else $error("failed allocate carries a page or flag");

	a_write_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en && (req_s1 == lfpa_pkg::REQ_ALLOC) |-> {1'b0, row_s1, sel_bit} < total_q)
		else $error("granted page outside pool");

endmodule

// ===== test/tb_lowest_free_page_allocator.sv =====
`timescale 1ns / 1ps

module tb_lowest_free_page_allocator;

	localparam int   PAGES       = lfpa_pkg::PAGES;
	localparam int   PAGE_W      = lfpa_pkg::PAGE_W;
	localparam int   CNT_W       = lfpa_pkg::CNT_W;
	localparam logic REQ_ALLOC   = lfpa_pkg::REQ_ALLOC;
	localparam logic REQ_RELEASE = lfpa_pkg::REQ_RELEASE;

	localparam int STALL_LIMIT  = 5000;
	localparam int SETTLE_WAIT  = 8;
	localparam int PHASES       = 9;
	localparam int PHASE_WORDS  = 80;
	localparam int MAX_PRINTS   = 50;
	localparam int POOL_SIZES [PHASES] = '{70, 1, 8191, 0, 130, 4095, 65, 4096, 200};
	localparam int ALLOC_PCT  [PHASES] = '{60, 55, 65, 50, 70, 60, 55, 75, 60};

	typedef struct packed {
		logic [PAGE_W-1:0]  page;
		logic               failed;
		logic               invalid;
		logic [CNT_W-1:0]   count;
	} grant_t;

	class page_pool_scoreboard;
		bit [PAGES-1:0] free_map;
		int             pool_size;
		int             free_left;
		int             top_granted;
		int unsigned    errors;
		grant_t         expected[$];

		function new();
			errors = 0;
			set_pool(CNT_W'(PAGES));
		endfunction

		// pool write rebuilds the map; sizes above PAGES saturate
		function void set_pool(logic [CNT_W-1:0] size);
			int n;
			n = (int'(size) > PAGES) ? PAGES : int'(size);
			pool_size   = n;
			free_left   = n;
			top_granted = 0;
			for (int i = 0; i < PAGES; i++)
				free_map[i] = (i < n);
		endfunction

		function void note_request(logic req, logic [PAGE_W-1:0] page);
			grant_t g;
			int     lowest;
			g = '0;
			if (req == REQ_ALLOC) begin
				lowest = -1;
				for (int i = 0; i < PAGES; i++) begin
					if (free_map[i]) begin
						lowest = i;
						break;
					end
				end
				if (lowest < 0) begin
					g.failed = 1'b1;
				end else begin
					free_map[lowest] = 1'b0;
					free_left--;
					g.page = lowest[PAGE_W-1:0];
					if (lowest > top_granted)
						top_granted = lowest;
				end
			end else if (int'(page) >= pool_size) begin
				g.invalid = 1'b1;
			end else if (!free_map[page]) begin
				free_map[page] = 1'b1;
				free_left++;
			end
			g.count = free_left[CNT_W-1:0];
			expected.push_back(g);
		endfunction

		function int pending();
			return expected.size();
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_PRINTS)
				$display("tb_lowest_free_page_allocator: mismatch %0d at %0t: %s",
					errors, $time, msg);
		endtask

		task check_result(logic [PAGE_W-1:0] page, logic failed, logic invalid,
				logic [CNT_W-1:0] count);
			grant_t want;
			if (expected.size() == 0) begin
				report($sformatf("result word with nothing pending (page %0d count %0d)",
					page, count));
			end else begin
				want = expected.pop_front();
				if (page !== want.page)
					report($sformatf("granted_page %0d, want %0d", page, want.page));
				if (failed !== want.failed)
					report($sformatf("alloc_failed %0b, want %0b", failed, want.failed));
				if (invalid !== want.invalid)
					report($sformatf("release_invalid %0b, want %0b", invalid, want.invalid));
				if (count !== want.count)
					report($sformatf("free_count %0d, want %0d", count, want.count));
			end
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CNT_W-1:0]   cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               req_type = REQ_ALLOC;
	logic [PAGE_W-1:0]  page_number = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [PAGE_W-1:0]  granted_page;
	logic               alloc_failed;
	logic               release_invalid;
	logic [CNT_W-1:0]   free_count;

	int                 tx_idle_pct = 25;
	int                 rx_idle_pct = 48;
	int                 quiet_cycles = 0;
	page_pool_scoreboard sb;

	lowest_free_page_allocator uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.req_type        (req_type),
		.page_number     (page_number),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.granted_page    (granted_page),
		.alloc_failed    (alloc_failed),
		.release_invalid (release_invalid),
		.free_count      (free_count)
	);

	always #1 clk = ~clk;

	// result side: check accepted words, then pick next cycle's ready
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(granted_page, alloc_failed, release_invalid, free_count);
		out_ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb_lowest_free_page_allocator: done, errors");
				$finish;
			end
		end
	end

	// entered and left on a rising edge; valid stays up after acceptance
	task automatic send_req(logic req, logic [PAGE_W-1:0] page);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= req;
		page_number <= page;
		do @(posedge clk); while (!in_ready);
		sb.note_request(req, page);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_WAIT) @(posedge clk);
	endtask

	task automatic write_pool(logic [CNT_W-1:0] size);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= size;
		do @(posedge clk); while (!cfg_ready);
		sb.set_pool(size);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int                 pick;
		int                 edge_page;
		logic [PAGE_W-1:0]  page;

		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full pool out of reset: grants, double release, lowest page reused
		send_req(REQ_ALLOC, 12'hFFF);
		send_req(REQ_ALLOC, 12'h000);
		send_req(REQ_RELEASE, 12'd0);
		send_req(REQ_RELEASE, 12'd0);
		send_req(REQ_RELEASE, 12'hFFF);
		send_req(REQ_RELEASE, 12'd1);
		send_req(REQ_ALLOC, 12'h000);

		// rewrite frees everything below the new size; exhaust a tiny pool
		write_pool(13'd2);
		send_req(REQ_ALLOC, 12'h000);
		send_req(REQ_ALLOC, 12'h000);
		send_req(REQ_ALLOC, 12'h000);
		send_req(REQ_RELEASE, 12'd2);
		send_req(REQ_RELEASE, 12'hFFF);
		send_req(REQ_RELEASE, 12'd1);
		send_req(REQ_ALLOC, 12'h000);

		write_pool(13'd0);
		send_req(REQ_ALLOC, 12'h000);
		send_req(REQ_RELEASE, 12'd0);

		// oversize write saturates to the full pool
		write_pool(13'h1FFF);
		send_req(REQ_RELEASE, 12'hFFF);
		send_req(REQ_ALLOC, 12'hFFF);

		write_pool(13'd4095);
		send_req(REQ_RELEASE, 12'hFFF);
		send_req(REQ_ALLOC, 12'h000);
		send_req(REQ_RELEASE, 12'd0);

		for (int ph = 0; ph < PHASES; ph++) begin
			tx_idle_pct = (ph < 3) ? 25 : (ph < 6) ? 48 : 0;
			rx_idle_pct = (ph < 3) ? 48 : (ph < 6) ? 25 : 0;
			write_pool(CNT_W'(POOL_SIZES[ph]));
			for (int k = 0; k < PHASE_WORDS; k++) begin
				if ($urandom_range(59) == 0)
					settle();
				if ($urandom_range(99) < ALLOC_PCT[ph]) begin
					send_req(REQ_ALLOC, PAGE_W'($urandom()));
				end else begin
					pick = $urandom_range(3);
					if (pick <= 1) begin
						// mostly pages handed out earlier in this phase
						page = PAGE_W'($urandom_range(sb.top_granted));
					end else if (pick == 2) begin
						page = PAGE_W'($urandom());
					end else begin
						edge_page = sb.pool_size + $urandom_range(3) - 2;
						if (edge_page < 0)
							edge_page = 0;
						if (edge_page > PAGES - 1)
							edge_page = PAGES - 1;
						page = edge_page[PAGE_W-1:0];
					end
					send_req(REQ_RELEASE, page);
				end
			end
		end

		settle();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb_lowest_free_page_allocator: done, clean");
		else
			$display("tb_lowest_free_page_allocator: done, errors");
		$finish;
	end

endmodule
